// File: rtl/mlc_pkg.sv
package mlc_pkg;

  localparam int OPERAND_BITS     = 31;
  localparam int MAX_RESULT_CHARS = 64;

  localparam int MAG_BITS   = 2 * OPERAND_BITS;
  localparam int BIN_DIGITS = MAG_BITS;
  localparam int OCT_DIGITS = (MAG_BITS + 2) / 3;
  localparam int HEX_DIGITS = (MAG_BITS + 3) / 4;
  localparam int DEC_DIGITS = (MAG_BITS * 301) / 1000 + 1;
  localparam int WORK_BITS  = 4 * DEC_DIGITS;
  localparam int CNT_BITS   = $clog2(MAG_BITS + 1);

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_OP    = 3'd1;
  localparam logic [2:0] ST_BAD_BASE  = 3'd2;
  localparam logic [2:0] ST_BAD_DIGIT = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  localparam logic [1:0] BASE_B = 2'd0;
  localparam logic [1:0] BASE_D = 2'd1;
  localparam logic [1:0] BASE_O = 2'd2;
  localparam logic [1:0] BASE_X = 2'd3;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SUB  = 2'd2;
  localparam logic [1:0] OP_MUL  = 2'd3;

  typedef struct packed {
    logic parse;
    logic calc;
    logic mag;
    logic prep;
    logic conv_step;
    logic norm_shift;
    logic put_single;
    logic put_sign;
    logic put_letter;
    logic put_digit;
    logic clear_err;
  } mlc_cmd_t;

  typedef struct packed {
    logic run_end;
    logic err;
    logic mag_zero;
    logic base_dec;
    logic top_zero;
    logic conv_last;
    logic len_over;
    logic neg;
    logic digit_last;
    logic can_put;
  } mlc_stat_t;

endpackage

// File: rtl/mlc_in_if.sv
interface mlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       token_end;

  modport source (output valid, output in_char, output token_end, input ready);
  modport sink (input valid, input in_char, input token_end, output ready);
endinterface

// File: rtl/mlc_out_if.sv
interface mlc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output out_char, output status, output last, input ready);
  modport sink (input valid, input out_char, input status, input last, output ready);
endinterface

// File: rtl/multibase_literal_calculator.sv
// Signed calculator over text: four tokens come in one character per word
// (operator, two base-prefixed operands, output base letter), token_end on
// the last character of each. Parsing takes one word per cycle. After the
// last token the block stops taking input, does the arithmetic in the CALC
// and MAG states (the 31x31 multiplier is registered), then for decimal
// output runs shift-add-3 conversion into a 19-digit BCD word; it then
// strips leading zero digits one per cycle (up to 61 for binary) and emits
// the text one character per cycle, as fast as the sink takes it. A run with
// an error emits a single status word with last set.
module multibase_literal_calculator
  import mlc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  mlc_in_if.sink   char_in,
  mlc_out_if.source char_out
);

  mlc_cmd_t  cmd;
  mlc_stat_t stat;

  // sequencer: parse, compute, convert, emit
  mlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (char_in.valid),
    .in_ready (char_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // token parsing, arithmetic, digit conversion and the output register
  mlc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_char   (char_in.in_char),
    .token_end (char_in.token_end),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (char_out.ready),
    .out_valid (char_out.valid),
    .out_char  (char_out.out_char),
    .status    (char_out.status),
    .last      (char_out.last)
  );

endmodule

// File: rtl/mlc_ctrl.sv
module mlc_ctrl
  import mlc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  mlc_stat_t stat,
  output mlc_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_PARSE, S_CALC, S_MAG, S_DECIDE, S_CONV, S_NORM,
    S_SINGLE, S_SIGN, S_LETTER, S_DIGIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_PARSE);
    case (state)
      S_PARSE: begin
        if (in_valid) begin
          cmd.parse = 1'b1;
          if (stat.run_end) state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_MAG;
      end
      S_MAG: begin
        cmd.mag    = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.err || stat.mag_zero) begin
          state_next = S_SINGLE;
        end else begin
          cmd.prep   = 1'b1;
          state_next = stat.base_dec ? S_CONV : S_NORM;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (stat.conv_last) state_next = S_NORM;
      end
      S_NORM: begin
        if (stat.top_zero) cmd.norm_shift = 1'b1;
        else if (stat.len_over) state_next = S_SINGLE;
        else if (stat.neg) state_next = S_SIGN;
        else state_next = S_LETTER;
      end
      S_SINGLE: begin
        if (stat.can_put) begin
          cmd.put_single = 1'b1;
          cmd.clear_err  = 1'b1;
          state_next     = S_PARSE;
        end
      end
      S_SIGN: begin
        if (stat.can_put) begin
          cmd.put_sign = 1'b1;
          state_next   = S_LETTER;
        end
      end
      S_LETTER: begin
        if (stat.can_put) begin
          cmd.put_letter = 1'b1;
          state_next     = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (stat.can_put) begin
          cmd.put_digit = 1'b1;
          if (stat.digit_last) begin
            cmd.clear_err = 1'b1;
            state_next    = S_PARSE;
          end
        end
      end
      default: state_next = S_PARSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_PARSE;
    else state <= state_next;
  end

endmodule

// File: rtl/mlc_dp.sv
module mlc_dp
  import mlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_char,
  input  logic       token_end,
  input  mlc_cmd_t   cmd,
  output mlc_stat_t  stat,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_char,
  output logic [2:0] status,
  output logic       last
);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam int SC_BITS = OPERAND_BITS + 5;
  localparam int SUM_BITS = OPERAND_BITS + 2;

  // parse state
  logic [1:0]              token_index;
  logic [6:0]              char_position;
  logic [1:0]              operator_code;
  logic [1:0]              current_base;
  logic                    current_negative;
  logic [OPERAND_BITS-1:0] accumulator;
  logic                    first_negative;
  logic [OPERAND_BITS-1:0] first_magnitude;
  logic [2:0]              error_code;
  // result state
  logic [MAG_BITS-1:0]     prod;
  logic [SUM_BITS-1:0]     sum;
  logic [MAG_BITS-1:0]     mag;
  logic                    neg;
  logic [WORK_BITS-1:0]    work;
  logic [CNT_BITS-1:0]     cnt;

  logic [1:0]              op_next, base_next;
  logic                    neg_next;
  logic [OPERAND_BITS-1:0] acc_next;
  logic [2:0]              err_cand;
  logic                    base_ok;
  logic [1:0]              base_code;
  logic [4:0]              dval, radix;
  logic [SC_BITS-1:0]      scaled, dsum;
  logic [SUM_BITS-1:0]     sa, sb, sum_abs;
  logic [3:0]              top;
  logic [3:0]              nib, adj;
  logic [WORK_BITS-1:0]    bcd_adj;
  logic [7:0]              len;

  always_comb begin
    base_ok   = 1'b1;
    base_code = BASE_D;
    case (in_char)
      8'h62:   base_code = BASE_B;
      8'h64:   base_code = BASE_D;
      8'h6F:   base_code = BASE_O;
      8'h78:   base_code = BASE_X;
      default: base_ok = 1'b0;
    endcase
  end

  always_comb begin
    if (in_char inside {[8'h30:8'h39]}) dval = 5'(in_char - 8'h30);
    else if (in_char inside {[8'h61:8'h66]}) dval = 5'(in_char - 8'h57);
    else if (in_char inside {[8'h41:8'h46]}) dval = 5'(in_char - 8'h37);
    else dval = 5'd31;
    case (current_base)
      BASE_B:  radix = 5'd2;
      BASE_O:  radix = 5'd8;
      BASE_X:  radix = 5'd16;
      default: radix = 5'd10;
    endcase
    case (current_base)
      BASE_B:  scaled = SC_BITS'(accumulator) << 1;
      BASE_O:  scaled = SC_BITS'(accumulator) << 3;
      BASE_X:  scaled = SC_BITS'(accumulator) << 4;
      default: scaled = (SC_BITS'(accumulator) << 3) + (SC_BITS'(accumulator) << 1);
    endcase
    dsum = scaled + SC_BITS'(dval);
  end

  // one character of the current token
  always_comb begin
    op_next  = operator_code;
    base_next = current_base;
    neg_next = current_negative;
    acc_next = accumulator;
    err_cand = ST_OK;
    case (token_index)
      2'd0: begin
        if (char_position == 7'd0) begin
          case (in_char)
            CH_PLUS:  op_next = OP_ADD;
            CH_MINUS: op_next = OP_SUB;
            CH_STAR:  op_next = OP_MUL;
            default: begin
              op_next  = OP_NONE;
              err_cand = ST_BAD_OP;
            end
          endcase
        end
      end
      2'd1, 2'd2: begin
        if (char_position == 7'd0) begin
          acc_next = '0;
          neg_next = 1'b0;
          base_next = BASE_D;
          if (in_char == CH_MINUS) begin
            neg_next = 1'b1;
            if (token_end) err_cand = ST_BAD_BASE;
          end else if (base_ok) begin
            base_next = base_code;
          end else begin
            err_cand = ST_BAD_BASE;
          end
        end else if (char_position == 7'd1 && current_negative) begin
          base_next = base_ok ? base_code : BASE_D;
          if (!base_ok) err_cand = ST_BAD_BASE;
        end else if (dval >= radix) begin
          err_cand = ST_BAD_DIGIT;
        end else if (|dsum[SC_BITS-1:OPERAND_BITS]) begin
          err_cand = ST_OVERFLOW;
          acc_next = '1;
        end else begin
          acc_next = dsum[OPERAND_BITS-1:0];
        end
      end
      default: begin
        if (char_position == 7'd0) begin
          base_next = base_ok ? base_code : BASE_D;
          if (!base_ok) err_cand = ST_BAD_BASE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_index      <= 2'd0;
      char_position    <= 7'd0;
      operator_code    <= OP_NONE;
      current_base     <= BASE_B;
      current_negative <= 1'b0;
      accumulator      <= '0;
      first_negative   <= 1'b0;
      first_magnitude  <= '0;
      error_code       <= ST_OK;
    end else begin
      if (cmd.parse) begin
        operator_code    <= op_next;
        current_base     <= base_next;
        current_negative <= neg_next;
        accumulator      <= acc_next;
        if (error_code == ST_OK) error_code <= err_cand;
        if (token_end) begin
          char_position <= 7'd0;
          token_index   <= token_index + 2'd1;
          if (token_index == 2'd1) begin
            first_magnitude <= acc_next;
            first_negative  <= neg_next;
          end
        end else if (char_position != 7'd127) begin
          char_position <= char_position + 7'd1;
        end
      end
      if (cmd.clear_err) error_code <= ST_OK;
    end
  end

  // arithmetic
  always_comb begin
    sa = first_negative ? -SUM_BITS'(first_magnitude) : SUM_BITS'(first_magnitude);
    sb = current_negative ? -SUM_BITS'(accumulator) : SUM_BITS'(accumulator);
    sum_abs = sum[SUM_BITS-1] ? -sum : sum;
  end

  always_comb begin
    case (current_base)
      BASE_B:  top = {3'b0, work[WORK_BITS-1]};
      BASE_O:  top = {1'b0, work[WORK_BITS-1 -: 3]};
      default: top = work[WORK_BITS-1 -: 4];
    endcase
    len = 8'(neg) + 8'd1 + 8'(cnt);
  end

  always_comb begin
    bcd_adj = work;
    nib = 4'd0;
    adj = 4'd0;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      nib = work[4*i +: 4];
      adj = (nib >= 4'd5) ? nib + 4'd3 : nib;
      bcd_adj[4*i +: 4] = adj;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      prod <= MAG_BITS'(first_magnitude) * MAG_BITS'(accumulator);
      sum  <= (operator_code == OP_SUB) ? sa - sb : sa + sb;
    end
    if (cmd.mag) begin
      if (operator_code == OP_MUL) begin
        mag <= prod;
        neg <= (first_negative ^ current_negative) && (prod != '0);
      end else begin
        mag <= MAG_BITS'(sum_abs);
        neg <= sum[SUM_BITS-1];
      end
    end
    if (cmd.prep) begin
      case (current_base)
        BASE_B: begin
          work <= WORK_BITS'(mag) << (WORK_BITS - BIN_DIGITS);
          cnt  <= CNT_BITS'(BIN_DIGITS);
        end
        BASE_O: begin
          work <= WORK_BITS'(mag) << (WORK_BITS - 3 * OCT_DIGITS);
          cnt  <= CNT_BITS'(OCT_DIGITS);
        end
        BASE_X: begin
          work <= WORK_BITS'(mag) << (WORK_BITS - 4 * HEX_DIGITS);
          cnt  <= CNT_BITS'(HEX_DIGITS);
        end
        default: begin
          work <= '0;
          cnt  <= CNT_BITS'(MAG_BITS);
        end
      endcase
    end
    if (cmd.conv_step) begin
      work <= {bcd_adj[WORK_BITS-2:0], mag[MAG_BITS-1]};
      mag  <= mag << 1;
      cnt  <= (cnt == CNT_BITS'(1)) ? CNT_BITS'(DEC_DIGITS) : cnt - CNT_BITS'(1);
    end
    if (cmd.norm_shift || cmd.put_digit) begin
      case (current_base)
        BASE_B:  work <= work << 1;
        BASE_O:  work <= work << 3;
        default: work <= work << 4;
      endcase
      cnt <= cnt - CNT_BITS'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put_single || cmd.put_sign || cmd.put_letter || cmd.put_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.put_single) begin
      last <= 1'b1;
      if (error_code != ST_OK) begin
        out_char <= 8'd0;
        status   <= error_code;
      end else if (mag == '0) begin
        out_char <= CH_ZERO;
        status   <= ST_OK;
      end else begin
        out_char <= 8'd0;
        status   <= ST_OVERFLOW;
      end
    end
    if (cmd.put_sign) begin
      out_char <= CH_MINUS;
      status   <= ST_OK;
      last     <= 1'b0;
    end
    if (cmd.put_letter) begin
      case (current_base)
        BASE_B:  out_char <= 8'h62;
        BASE_O:  out_char <= 8'h6F;
        BASE_X:  out_char <= 8'h78;
        default: out_char <= 8'h64;
      endcase
      status <= ST_OK;
      last   <= 1'b0;
    end
    if (cmd.put_digit) begin
      out_char <= (top < 4'd10) ? 8'(top) + 8'd48 : 8'(top) + 8'd55;
      status   <= ST_OK;
      last     <= (cnt == CNT_BITS'(1));
    end
  end

  assign stat.run_end    = token_end && (token_index == 2'd3);
  assign stat.err        = (error_code != ST_OK);
  assign stat.mag_zero   = (mag == '0);
  assign stat.base_dec   = (current_base == BASE_D);
  assign stat.top_zero   = (top == 4'd0);
  assign stat.conv_last  = (cnt == CNT_BITS'(1));
  assign stat.len_over   = (len > 8'(MAX_RESULT_CHARS));
  assign stat.neg        = neg;
  assign stat.digit_last = (cnt == CNT_BITS'(1));
  assign stat.can_put    = !out_valid || out_ready;

endmodule
